FILE: sv/lor_pkg.sv
package lor_pkg;

  // port field widths and grid size reset value
  localparam int unsigned AreaOutW = 11;
  localparam int unsigned BoundOutW = 5;
  localparam int unsigned RowBitsW = 32;
  localparam int unsigned GridCfgW = 6;
  localparam logic [GridCfgW-1:0] GridSizeReset = 6'd11;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_row;
    logic push;
    logic pop;
    logic finish_row;
    logic finish_grid;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pop_req;
    logic pop_ok;
    logic col_end;
    logic last_row;
    logic out_busy;
  } status_t;

endpackage

FILE: sv/lor_stack_ram.sv
module lor_stack_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

FILE: sv/lor_ctrl.sv
module lor_ctrl import lor_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_row = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status_i.pop_req) begin
          // hold the pop while the entry below the top is still being read
          if (status_i.pop_ok) begin
            cmd_o.pop = 1'b1;
          end
        end else if (status_i.col_end) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.push = 1'b1;
        end
      end
      ST_DONE: begin
        if (status_i.last_row) begin
          if (!status_i.out_busy) begin
            cmd_o.finish_grid = 1'b1;
            state_d           = ST_IDLE;
          end
        end else begin
          cmd_o.finish_row = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/lor_datapath.sv
module lor_datapath import lor_pkg::*; #(
  parameter int unsigned MAX_DIM = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmd_t                              cmd_i,
  output status_t                           status_o,
  input  logic [$clog2(MAX_DIM+1)-1:0]      size_i,
  input  logic [RowBitsW-1:0]               row_bits_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              found_o,
  output logic [AreaOutW-1:0]               area_o,
  output logic [BoundOutW-1:0]              first_row_o,
  output logic [BoundOutW-1:0]              last_row_o,
  output logic [BoundOutW-1:0]              first_col_o,
  output logic [BoundOutW-1:0]              last_col_o
);

  localparam int unsigned SZW = $clog2(MAX_DIM + 1);
  localparam int unsigned CW  = $clog2(MAX_DIM);
  localparam int unsigned HW  = SZW;
  localparam int unsigned PW  = HW + SZW;
  localparam int unsigned AW  = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned EW  = CW + CW + HW;

  // column heights and the shifting copy the scan walks through
  logic [HW-1:0]  heights_q [MAX_DIM];
  logic [HW-1:0]  scan_q    [MAX_DIM];
  logic [HW-1:0]  new_h     [MAX_DIM];
  logic [MAX_DIM-1:0] col_one;

  // scan position and stack top
  logic [SZW-1:0] col_q;
  logic [SZW-1:0] cnt_q;
  logic [CW-1:0]  top_idx_q;
  logic [CW-1:0]  top_left_q;
  logic [HW-1:0]  top_h_q;
  logic           stable_q;
  logic [CW-1:0]  row_q;

  // best rectangle so far
  logic [AW-1:0]  best_area_q;
  logic [CW-1:0]  best_top_q;
  logic [CW-1:0]  best_bottom_q;
  logic [CW-1:0]  best_left_q;
  logic [CW-1:0]  best_right_q;

  logic [HW-1:0]  h_cur;
  logic [CW-1:0]  push_left;
  logic [SZW-1:0] span;
  logic [PW-1:0]  prod;
  logic [AW-1:0]  cand_area;
  logic           take;
  logic [EW-1:0]  wr_entry;
  logic [EW-1:0]  rd_entry;
  logic [CW-1:0]  wr_addr;
  logic [CW-1:0]  rd_addr;

  // bits of the row that count, per column
  for (genvar k = 0; k < MAX_DIM; k++) begin : g_col
    if (k < RowBitsW) begin : g_bit
      assign col_one[k] = row_bits_i[k] && (SZW'(k) < size_i);
    end else begin : g_zero
      assign col_one[k] = 1'b0;
    end
    assign new_h[k] = col_one[k] ? HW'(heights_q[k] + HW'(1)) : '0;
  end

  // current bar, with the zero sentinel past the last column
  assign h_cur = (col_q == size_i) ? '0 : scan_q[0];

  // left edge of a bar pushed now
  assign push_left = (cnt_q == '0) ? '0 : CW'(top_idx_q + CW'(1));

  // candidate rectangle for the popped bar
  assign span      = col_q - SZW'(top_left_q);
  assign prod      = PW'(top_h_q) * PW'(span);
  assign cand_area = AW'(prod);
  assign take      = (top_h_q != '0) && (cand_area > best_area_q);

  // stack memory: entries below the top
  assign wr_entry = {top_idx_q, top_left_q, top_h_q};
  assign wr_addr  = CW'(cnt_q - SZW'(1));
  assign rd_addr  = CW'(cnt_q - SZW'(2));

  lor_stack_ram #(
    .DEPTH(MAX_DIM),
    .WIDTH(EW)
  ) u_stack (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.push && (cnt_q != '0)),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_entry),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_entry)
  );

  // status
  always_comb begin
    status_o.pop_req  = (cnt_q != '0) && (top_h_q >= h_cur);
    status_o.pop_ok   = (cnt_q < SZW'(2)) || stable_q;
    status_o.col_end  = (col_q == size_i);
    status_o.last_row = (SZW'(row_q) + SZW'(1)) >= size_i;
    status_o.out_busy = out_valid_o && !out_ready_i;
  end

  // heights and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_DIM; k++) begin
        heights_q[k] <= '0;
      end
      row_q <= '0;
    end else begin
      priority if (cmd_i.load_row) begin
        for (int k = 0; k < MAX_DIM; k++) begin
          heights_q[k] <= new_h[k];
        end
      end else if (cmd_i.finish_grid) begin
        for (int k = 0; k < MAX_DIM; k++) begin
          heights_q[k] <= '0;
        end
        row_q <= '0;
      end else if (cmd_i.finish_row) begin
        row_q <= CW'(row_q + CW'(1));
      end
    end
  end

  // scan copy shifts one column on each push
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      for (int k = 0; k < MAX_DIM; k++) begin
        scan_q[k] <= new_h[k];
      end
    end else if (cmd_i.push) begin
      for (int k = 0; k < MAX_DIM - 1; k++) begin
        scan_q[k] <= scan_q[k+1];
      end
      scan_q[MAX_DIM-1] <= '0;
    end
  end

  // scan control and stack count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      cnt_q    <= '0;
      stable_q <= 1'b0;
    end else begin
      stable_q <= !(cmd_i.push || cmd_i.pop);
      priority if (cmd_i.load_row) begin
        col_q <= '0;
        cnt_q <= '0;
      end else if (cmd_i.push) begin
        col_q <= SZW'(col_q + SZW'(1));
        cnt_q <= SZW'(cnt_q + SZW'(1));
      end else if (cmd_i.pop) begin
        cnt_q <= SZW'(cnt_q - SZW'(1));
      end
    end
  end

  // stack top registers
  always_ff @(posedge clk_i) begin
    priority if (cmd_i.push) begin
      top_idx_q  <= CW'(col_q);
      top_left_q <= push_left;
      top_h_q    <= h_cur;
    end else if (cmd_i.pop) begin
      {top_idx_q, top_left_q, top_h_q} <= rd_entry;
    end
  end

  // best rectangle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_area_q   <= '0;
      best_top_q    <= '0;
      best_bottom_q <= '0;
      best_left_q   <= '0;
      best_right_q  <= '0;
    end else begin
      priority if (cmd_i.finish_grid) begin
        best_area_q   <= '0;
        best_top_q    <= '0;
        best_bottom_q <= '0;
        best_left_q   <= '0;
        best_right_q  <= '0;
      end else if (cmd_i.pop && take) begin
        best_area_q   <= cand_area;
        best_top_q    <= CW'(SZW'(row_q) + SZW'(1) - SZW'(top_h_q));
        best_bottom_q <= row_q;
        best_left_q   <= top_left_q;
        best_right_q  <= CW'(col_q - SZW'(1));
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      priority if (cmd_i.finish_grid) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_grid) begin
      found_o     <= (best_area_q != '0);
      area_o      <= AreaOutW'(best_area_q);
      first_row_o <= BoundOutW'(best_top_q);
      last_row_o  <= BoundOutW'(best_bottom_q);
      first_col_o <= BoundOutW'(best_left_q);
      last_col_o  <= BoundOutW'(best_right_q);
    end
  end

endmodule

FILE: sv/largest_ones_rectangle.sv
// channel | direction | handshake                   | payload
// row     | in        | in_valid_i / in_ready_o     | row_bits_i
// config  | in        | cfg_we_i                    | cfg_wdata_i (grid size)
// result  | out       | out_valid_o / out_ready_i   | found_o, area_o, bounds
//
// a row is scanned with one push per column of the grid size in use and one
// pop per pushed bar; the stack memory's registered read makes a pop right
// after a stack change wait.
// reset clears heights, row count and best rectangle at once; no clearing pass.
// a finished result waits in its output register while the next grid's rows
// are taken; only the last row of that grid stalls on a result not yet taken.
module largest_ones_rectangle import lor_pkg::*; #(
  parameter int unsigned MAX_DIM = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RowBitsW-1:0]   row_bits_i,
  input  logic                  cfg_we_i,
  input  logic [GridCfgW-1:0]   cfg_wdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [AreaOutW-1:0]   area_o,
  output logic [BoundOutW-1:0]  first_row_o,
  output logic [BoundOutW-1:0]  last_row_o,
  output logic [BoundOutW-1:0]  first_col_o,
  output logic [BoundOutW-1:0]  last_col_o
);

  localparam int unsigned SZW = $clog2(MAX_DIM + 1);

  logic [GridCfgW-1:0] grid_q;
  logic [SZW-1:0]      size;
  cmd_t                cmd;
  status_t             status;

  // grid size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= GridSizeReset;
    end else if (cfg_we_i) begin
      grid_q <= cfg_wdata_i;
    end
  end

  // size in use, clamped to one and to the largest grid
  always_comb begin
    priority if (grid_q == '0) begin
      size = SZW'(1);
    end else if (int'(grid_q) > int'(MAX_DIM)) begin
      size = SZW'(MAX_DIM);
    end else begin
      size = SZW'(grid_q);
    end
  end

  lor_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  lor_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .size_i     (size),
    .row_bits_i (row_bits_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .found_o    (found_o),
    .area_o     (area_o),
    .first_row_o(first_row_o),
    .last_row_o (last_row_o),
    .first_col_o(first_col_o),
    .last_col_o (last_col_o)
  );

endmodule
